### rtl/bxps_pkg.sv
// Shared constants and types for the Bezier x-to-parameter search block.
package bxps_pkg;

	localparam int DEF_PARAM_FRAC_BITS = 24;
	localparam int DEF_COORD_WIDTH     = 32;

	localparam int TOL_W       = 16;
	localparam int STEPS_W     = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS = 1'd1;

	localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd1;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd40;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ABC  = 7'b0000010,
		ST_DE   = 7'b0000100,
		ST_F    = 7'b0001000,
		ST_CMP  = 7'b0010000,
		ST_MID  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage

### rtl/bxps_if.sv
// Handshake channel interfaces: configuration writes, search requests, results.
interface bxps_cfg_if
	import bxps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface bxps_req_if #(
	parameter int W = 32
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] target_x;
	logic signed [W-1:0] start_x;
	logic signed [W-1:0] end_x;
	logic signed [W-1:0] first_control_x;
	logic signed [W-1:0] second_control_x;
	modport source(output valid, target_x, start_x, end_x, first_control_x,
		second_control_x, input ready);
	modport sink(input valid, target_x, start_x, end_x, first_control_x,
		second_control_x, output ready);
endinterface

interface bxps_rsp_if #(
	parameter int PW = 25
) ();
	logic          valid;
	logic          ready;
	logic [PW-1:0] curve_parameter;
	modport source(output valid, curve_parameter, input ready);
	modport sink(input valid, curve_parameter, output ready);
endinterface

### rtl/bezier_x_to_parameter_search_top.sv
// Cubic Bezier x-to-parameter search by de Casteljau bisection.
// When the target lies at or beyond an end point the search goes straight to the
// result; otherwise each subdivision step makes three halving passes through the shared
// half-sum unit, then the error compare, up to the default limit of 40 steps.
// One word in flight; a new word is taken once the previous result is registered.
// Reset (arst_n low, async): tolerance 1, max_steps 40, channels idle.
module bezier_x_to_parameter_search_top
	import bxps_pkg::*;
#(
	parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS,
	parameter int COORD_WIDTH     = DEF_COORD_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	bxps_cfg_if.sink  cfg,
	bxps_req_if.sink  req,
	bxps_rsp_if.source rsp
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = PARAM_FRAC_BITS + 1;
	localparam logic [PW-1:0] ONE_PARAM = PW'(1) << PARAM_FRAC_BITS;

	function automatic logic signed [W-1:0] half_sum(logic signed [W-1:0] p,
		logic signed [W-1:0] q);
		logic signed [W:0] s;
		s = {p[W-1], p} + {q[W-1], q};
		return s[W:1];
	endfunction

	state_t state_q;

	logic [TOL_W-1:0]   tol_q;
	logic [STEPS_W-1:0] max_steps_q;
	logic [STEPS_W-1:0] cnt_q;

	logic signed [W-1:0] tx_q, p0_q, c0_q, c1_q, p1_q;
	logic signed [W-1:0] a_q, b_q, c_q, d_q, e_q, f_q;
	logic [PW-1:0]       lo_q, hi_q, res_q, out_q;
	logic                out_vq;

	// shared half-sum unit, three lanes, operands chosen by phase
	logic signed [W-1:0] op_x [3];
	logic signed [W-1:0] op_y [3];
	logic signed [W-1:0] hs   [3];

	always_comb begin
		op_x[0] = p0_q; op_y[0] = c0_q;
		op_x[1] = c0_q; op_y[1] = c1_q;
		op_x[2] = c1_q; op_y[2] = p1_q;
		case (state_q)
			ST_DE: begin
				op_x[0] = a_q; op_y[0] = b_q;
				op_x[1] = b_q; op_y[1] = c_q;
			end
			ST_F: begin
				op_x[0] = d_q; op_y[0] = e_q;
			end
			default: ;
		endcase
		for (int i = 0; i < 3; i++)
			hs[i] = half_sum(op_x[i], op_y[i]);
	end

	logic signed [W:0] err;
	logic [W:0]        err_abs;
	logic              hit;
	logic              below;
	logic [PW:0]       mid_sum;
	logic [PW-1:0]     mid;

	assign err     = {f_q[W-1], f_q} - {tx_q[W-1], tx_q};
	assign below   = err[W];
	assign err_abs = below ? (W+1)'(-err) : err;
	assign hit     = err_abs < (W+1)'(tol_q);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[PW:1];

	logic out_free;
	assign out_free = !out_vq || rsp.ready;

	// settings change only between searches; a pending search word goes first
	assign req.ready           = (state_q == ST_IDLE);
	assign cfg.ready           = (state_q == ST_IDLE) && !req.valid;
	assign rsp.valid           = out_vq;
	assign rsp.curve_parameter = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			max_steps_q <= STEPS_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_TOLERANCE: tol_q       <= cfg.data[TOL_W-1:0];
				CFG_MAX_STEPS: max_steps_q <= cfg.data[STEPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_vq  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (state_q == ST_FIN && out_free)
				out_vq <= 1'b1;
			else if (rsp.ready)
				out_vq <= 1'b0;
			case (state_q)
				ST_IDLE: if (req.valid) begin
					cnt_q <= '0;
					if (req.target_x <= req.start_x || req.end_x <= req.target_x)
						state_q <= ST_FIN;
					else if (max_steps_q == '0)
						state_q <= ST_MID;
					else
						state_q <= ST_ABC;
				end
				ST_ABC: state_q <= ST_DE;
				ST_DE:  state_q <= ST_F;
				ST_F:   state_q <= ST_CMP;
				ST_CMP: begin
					if (hit || STEPS_W'(cnt_q + 1'b1) == max_steps_q)
						state_q <= ST_MID;
					else
						state_q <= ST_ABC;
					cnt_q <= STEPS_W'(cnt_q + 1'b1);
				end
				ST_MID: state_q <= ST_FIN;
				ST_FIN: if (out_free)
					state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (req.valid) begin
				tx_q <= req.target_x;
				p0_q <= req.start_x;
				p1_q <= req.end_x;
				c0_q <= req.first_control_x;
				c1_q <= req.second_control_x;
				lo_q <= '0;
				hi_q <= ONE_PARAM;
				if (req.target_x <= req.start_x)
					res_q <= '0;
				else
					res_q <= ONE_PARAM;
			end
			ST_ABC: begin
				a_q <= hs[0];
				b_q <= hs[1];
				c_q <= hs[2];
			end
			ST_DE: begin
				d_q <= hs[0];
				e_q <= hs[1];
			end
			ST_F: f_q <= hs[0];
			ST_CMP: if (!hit) begin
				if (below) begin
					p0_q <= f_q;
					c0_q <= e_q;
					c1_q <= c_q;
					lo_q <= mid;
				end else begin
					c0_q <= a_q;
					c1_q <= d_q;
					p1_q <= f_q;
					hi_q <= mid;
				end
			end
			ST_MID: res_q <= mid;
			ST_FIN: if (out_free)
				out_q <= res_q;
			default: ;
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q != ST_IDLE)
		else $error("accepted word did not start a search");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ABC || state_q == ST_CMP) |-> cnt_q < max_steps_q)
		else $error("step count past limit");

	// the interval shrinks to at most one LSB once the steps pass the fraction width
	a_interval_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ABC || state_q == ST_MID) |-> lo_q <= hi_q && hi_q <= ONE_PARAM)
		else $error("parameter interval out of order");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.curve_parameter <= ONE_PARAM)
		else $error("result above one");

endmodule
